### rtl/sorted_dictionary_encoder_defines.svh
// assertion macros for the sorted dictionary encoder rtl
`ifndef SORTED_DICTIONARY_ENCODER_DEFINES_SVH
`define SORTED_DICTIONARY_ENCODER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define SDE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define SDE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/sde_pkg.sv
// types, codes and defaults shared by the sorted dictionary encoder
package sde_pkg;

  localparam int CAPACITY_DEF = 256;
  localparam int KEY_W        = 32;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_SEARCH = 2'd1,
    FUNC_LOOKUP = 2'd2
  } sde_func_t;

  typedef enum logic [2:0] {
    OP_EQ   = 3'd0,
    OP_NE   = 3'd1,
    OP_LT   = 3'd2,
    OP_LE   = 3'd3,
    OP_GT   = 3'd4,
    OP_GE   = 3'd5,
    OP_LIKE = 3'd6
  } sde_op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RANGE = 2'd3
  } sde_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BS_RD,
    ST_BS_CMP,
    ST_HIT_CHK,
    ST_SHIFT,
    ST_INS_WR,
    ST_LK_RD,
    ST_LK_WAIT,
    ST_DONE
  } sde_state_t;

  typedef struct packed {
    logic [1:0]       func;
    logic [KEY_W-1:0] key;
    logic [2:0]       op;
    logic [7:0]       index;
  } sde_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [7:0]       position;
    logic             was_added;
    logic [8:0]       range_first;
    logic [8:0]       range_end;
    logic             has_excluded;
    logic [7:0]       excluded_position;
    logic [KEY_W-1:0] entry_value;
  } sde_rsp_t;

endpackage

### rtl/sde_engine.sv
// dictionary sequencer: key memory, binary search, insert shift and lookup
`include "sorted_dictionary_encoder_defines.svh"

module sde_engine #(
  parameter int CAPACITY = sde_pkg::CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  sde_pkg::sde_req_t req,
  output logic              idle,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output sde_pkg::sde_rsp_t rsp
);
  import sde_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CW > 8) ? CW : 8;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic [KEY_W-1:0] mem [CAPACITY];
  logic [KEY_W-1:0] rdata_r;

  sde_state_t       state_r, state_nxt;
  sde_req_t         req_r, req_nxt;
  sde_rsp_t         rsp_r, rsp_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    lo_r, lo_nxt;
  logic [CW-1:0]    hi_r, hi_nxt;
  logic [AW-1:0]    mid_r, mid_nxt;
  logic [CW-1:0]    sh_ptr_r, sh_ptr_nxt;
  logic [AW-1:0]    wr_addr_r, wr_addr_nxt;
  logic             wr_pend_r, wr_pend_nxt;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [KEY_W-1:0] mem_wdata;
  logic [AW-1:0]    mem_raddr;

  logic [CW-1:0]    mid_c;
  logic [CW-1:0]    sh_prev_c;
  logic [CW-1:0]    after_c;
  logic             hit_c;
  logic             fin_c;
  logic             lk_ok_c;
  logic             full_c;

  assign mid_c     = lo_r + ((hi_r - lo_r) >> 1);
  assign sh_prev_c = sh_ptr_r - CW'(1);
  assign hit_c     = (state_r == ST_HIT_CHK) && (rdata_r == req_r.key);
  assign after_c   = hit_c ? (lo_r + CW'(1)) : lo_r;
  assign fin_c     = ((state_r == ST_BS_RD) && (lo_r >= hi_r) && (lo_r >= count_r)) ||
                     (state_r == ST_HIT_CHK);
  assign lk_ok_c   = IW'(req.index) < IW'(count_r);
  assign full_c    = (count_r == CAP_C);

  assign idle      = (state_r == ST_IDLE);
  assign rsp_valid = (state_r == ST_DONE);
  assign rsp       = rsp_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (req.func)
            FUNC_INSERT: state_nxt = ST_BS_RD;
            FUNC_SEARCH: state_nxt = (count_r == '0) ? ST_DONE : ST_BS_RD;
            FUNC_LOOKUP: state_nxt = lk_ok_c ? ST_LK_RD : ST_DONE;
            default:     state_nxt = ST_DONE;
          endcase
        end
      end
      ST_BS_RD: begin
        if (lo_r < hi_r) begin
          state_nxt = ST_BS_CMP;
        end else if (lo_r < count_r) begin
          state_nxt = ST_HIT_CHK;
        end else if (req_r.func == FUNC_INSERT && !full_c) begin
          state_nxt = ST_SHIFT;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_BS_CMP:  state_nxt = ST_BS_RD;
      ST_HIT_CHK: begin
        if (req_r.func == FUNC_INSERT && !hit_c && !full_c) begin
          state_nxt = ST_SHIFT;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_SHIFT:   state_nxt = (sh_ptr_r == lo_r) ? ST_INS_WR : ST_SHIFT;
      ST_INS_WR:  state_nxt = ST_DONE;
      ST_LK_RD:   state_nxt = ST_LK_WAIT;
      ST_LK_WAIT: state_nxt = ST_DONE;
      ST_DONE:    state_nxt = rsp_ready ? ST_IDLE : ST_DONE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    req_nxt     = req_r;
    rsp_nxt     = rsp_r;
    count_nxt   = count_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    mid_nxt     = mid_r;
    sh_ptr_nxt  = sh_ptr_r;
    wr_addr_nxt = wr_addr_r;
    wr_pend_nxt = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = wr_addr_r;
    mem_wdata   = rdata_r;
    mem_raddr   = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          req_nxt = req;
          rsp_nxt = '0;
          lo_nxt  = '0;
          hi_nxt  = count_r;
          case (req.func)
            FUNC_INSERT: rsp_nxt.status = STAT_OK;
            FUNC_SEARCH: rsp_nxt.status = (count_r == '0) ? STAT_EMPTY : STAT_OK;
            FUNC_LOOKUP: rsp_nxt.status = lk_ok_c ? STAT_OK : STAT_RANGE;
            default:     rsp_nxt.status = STAT_EMPTY;
          endcase
        end
      end
      ST_BS_RD: begin
        if (lo_r < hi_r) begin
          mid_nxt   = mid_c[AW-1:0];
          mem_raddr = mid_c[AW-1:0];
        end else begin
          mem_raddr = lo_r[AW-1:0];
        end
      end
      ST_BS_CMP: begin
        if ($signed(rdata_r) < $signed(req_r.key)) begin
          lo_nxt = CW'(mid_r) + CW'(1);
        end else begin
          hi_nxt = CW'(mid_r);
        end
      end
      ST_SHIFT: begin
        if (wr_pend_r) begin
          mem_we = 1'b1;
        end
        if (sh_ptr_r != lo_r) begin
          mem_raddr   = sh_prev_c[AW-1:0];
          wr_addr_nxt = sh_ptr_r[AW-1:0];
          wr_pend_nxt = 1'b1;
          sh_ptr_nxt  = sh_prev_c;
        end
      end
      ST_INS_WR: begin
        mem_we            = 1'b1;
        mem_waddr         = lo_r[AW-1:0];
        mem_wdata         = req_r.key;
        count_nxt         = count_r + CW'(1);
        rsp_nxt.position  = 8'(lo_r);
        rsp_nxt.was_added = 1'b1;
      end
      ST_LK_RD: begin
        mem_raddr = AW'(IW'(req_r.index));
      end
      ST_LK_WAIT: begin
        rsp_nxt.entry_value = rdata_r;
      end
      default: begin
      end
    endcase

    // end of search phase
    if (fin_c) begin
      sh_ptr_nxt = count_r;
      if (req_r.func == FUNC_INSERT) begin
        if (hit_c) begin
          rsp_nxt.position = 8'(lo_r);
        end else if (full_c) begin
          rsp_nxt.status = STAT_FULL;
        end
      end else begin
        case (req_r.op)
          OP_EQ: begin
            if (hit_c) begin
              rsp_nxt.position    = 8'(lo_r);
              rsp_nxt.range_first = 9'(lo_r);
              rsp_nxt.range_end   = 9'(after_c);
            end else begin
              rsp_nxt.status = STAT_EMPTY;
            end
          end
          OP_NE: begin
            rsp_nxt.range_end         = 9'(count_r);
            rsp_nxt.has_excluded      = hit_c;
            rsp_nxt.excluded_position = hit_c ? 8'(lo_r) : 8'd0;
          end
          OP_LT: rsp_nxt.range_end = 9'(lo_r);
          OP_LE: rsp_nxt.range_end = 9'(after_c);
          OP_GT: begin
            rsp_nxt.range_first = 9'(after_c);
            rsp_nxt.range_end   = 9'(count_r);
          end
          OP_GE: begin
            rsp_nxt.range_first = 9'(lo_r);
            rsp_nxt.range_end   = 9'(count_r);
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      wr_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      wr_pend_r <= wr_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    rsp_r     <= rsp_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    mid_r     <= mid_nxt;
    sh_ptr_r  <= sh_ptr_nxt;
    wr_addr_r <= wr_addr_nxt;
  end

  // key store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  `SDE_ASSERT_IMP(a_count_cap, clk, rst_n, 1'b1, count_r <= CAP_C, "key count above capacity")
  `SDE_ASSERT_NXT(a_count_inc, clk, rst_n, state_r == ST_INS_WR,
                  count_r == $past(count_r) + CW'(1), "insert did not bump key count")
  `SDE_ASSERT_IMP(a_bs_bounds, clk, rst_n, state_r == ST_BS_RD || state_r == ST_BS_CMP,
                  lo_r <= hi_r && hi_r <= count_r, "search bounds out of order")
  `SDE_ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready,
                  rsp_valid && $stable(rsp_r), "result dropped while stalled")

endmodule

### rtl/sorted_dictionary_encoder.sv
// sorted dictionary encoder: stream ports, request capture and result register
// insert: a binary search over the n stored keys, then a shift of the entries above
//   the insert position, moving one entry per cycle through the key memory write port
// search: a binary search, one memory read per probe
// lookup: a single memory read; one item in flight, the result register frees the engine
// reset clears the key count and control; the key memory is not cleared
module sorted_dictionary_encoder #(
  parameter int CAPACITY = sde_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // key[31:0], op[34:32], index[42:35], zero fill
  input  logic [1:0]  in_tuser,   // func[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // position, was_added, range_first, range_end,
                                  // has_excluded, excluded_position, entry_value, zero fill
  output logic [1:0]  out_tuser   // status[1:0]
);
  import sde_pkg::*;

  sde_req_t req;
  sde_rsp_t rsp;
  sde_rsp_t out_rsp_r;
  logic     out_valid_r, out_valid_nxt;
  logic     eng_idle;
  logic     rsp_valid;
  logic     rsp_ready;
  logic     start;

  assign req.func  = in_tuser;
  assign req.key   = in_tdata[31:0];
  assign req.op    = in_tdata[34:32];
  assign req.index = in_tdata[42:35];

  assign in_tready = eng_idle;
  assign start     = in_tvalid && eng_idle;
  assign rsp_ready = !out_valid_r || out_tready;

  sde_engine #(
    .CAPACITY (CAPACITY)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .req       (req),
    .idle      (eng_idle),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (rsp_ready) begin
      out_valid_nxt = rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_ready && rsp_valid) begin
      out_rsp_r <= rsp;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_rsp_r.status;
  assign out_tdata  = {4'd0,
                       out_rsp_r.entry_value,
                       out_rsp_r.excluded_position,
                       out_rsp_r.has_excluded,
                       out_rsp_r.range_end,
                       out_rsp_r.range_first,
                       out_rsp_r.was_added,
                       out_rsp_r.position};

endmodule

### dv/sorted_dictionary_encoder_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the sorted dictionary encoder stream block
module sorted_dictionary_encoder_tb;
  import sde_pkg::*;

  localparam int         DEPTH        = CAPACITY_DEF;
  localparam int         GROW_ITEMS   = 380;
  localparam int         FULL_ITEMS   = 330;
  localparam int         CALM_TAIL    = 120;
  localparam int         DRAIN_CYCLES = 320;
  localparam longint     CYCLE_LIMIT  = 1_200_000;
  localparam logic [1:0] FUNC_UNUSED  = 2'd3;
  localparam logic [2:0] OP_UNUSED    = 3'd7;

  typedef struct {
    sde_req_t req;
    bit       known;
    sde_rsp_t rsp;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // key[31:0], op[34:32], index[42:35], zero fill
  logic [1:0]  in_tuser;   // func[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;  // position, was_added, range_first, range_end,
                           // has_excluded, excluded_position, entry_value, zero fill
  logic [1:0]  out_tuser;  // status[1:0]

  logic [31:0] dict_keys [DEPTH];
  int          dict_count = 0;
  sde_rsp_t    pending_q[$];
  int          errors = 0;
  longint      cycles = 0;
  bit          calm = 1'b0;
  int          gap_odds = 25;
  int          stall_odds = 10;
  int          n_sent = 0, n_added = 0, n_full = 0, n_search = 0, n_lookup = 0;

  always #2 clk = ~clk;

  sorted_dictionary_encoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  function automatic int dict_lower_bound(logic [31:0] k);
    int lo = 0;
    int hi = dict_count;
    int mid;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if ($signed(dict_keys[mid]) < $signed(k)) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic sde_rsp_t dict_apply(sde_req_t r);
    sde_rsp_t res = '0;
    int       lb;
    int       after;
    bit       hit;
    case (r.func)
      FUNC_INSERT: begin
        lb  = dict_lower_bound(r.key);
        hit = lb < dict_count && dict_keys[lb] == r.key;
        if (hit) begin
          res.position = 8'(lb);
        end else if (dict_count >= DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          for (int i = dict_count; i > lb; i--) dict_keys[i] = dict_keys[i-1];
          dict_keys[lb] = r.key;
          dict_count++;
          res.position  = 8'(lb);
          res.was_added = 1'b1;
        end
      end
      FUNC_SEARCH: begin
        if (dict_count == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          lb    = dict_lower_bound(r.key);
          hit   = lb < dict_count && dict_keys[lb] == r.key;
          after = hit ? lb + 1 : lb;
          case (r.op)
            OP_EQ: begin
              if (hit) begin
                res.position    = 8'(lb);
                res.range_first = 9'(lb);
                res.range_end   = 9'(lb + 1);
              end else begin
                res.status = STAT_EMPTY;
              end
            end
            OP_NE: begin
              res.range_end = 9'(dict_count);
              if (hit) begin
                res.has_excluded      = 1'b1;
                res.excluded_position = 8'(lb);
              end
            end
            OP_LT: res.range_end = 9'(lb);
            OP_LE: res.range_end = 9'(after);
            OP_GT: begin
              res.range_first = 9'(after);
              res.range_end   = 9'(dict_count);
            end
            OP_GE: begin
              res.range_first = 9'(lb);
              res.range_end   = 9'(dict_count);
            end
            default: ;
          endcase
        end
      end
      FUNC_LOOKUP: begin
        if (int'(r.index) < dict_count) res.entry_value = dict_keys[r.index];
        else res.status = STAT_RANGE;
      end
      default: res.status = STAT_EMPTY;
    endcase
    return res;
  endfunction

  function automatic logic [31:0] pick_key();
    int unsigned sel = $urandom_range(0, 9);
    logic [31:0] k = $urandom();
    if (dict_count > 0 && sel < 4) begin
      k = dict_keys[$urandom_range(0, dict_count - 1)];
    end else if (dict_count > 0 && sel < 6) begin
      k = dict_keys[$urandom_range(0, dict_count - 1)];
      k = $urandom_range(0, 1) ? k + 32'd1 : k - 32'd1;
    end else if (sel == 6) begin
      case ($urandom_range(0, 3))
        0:       k = 32'h8000_0000;
        1:       k = 32'h7fff_ffff;
        2:       k = 32'h0000_0000;
        default: k = 32'hffff_ffff;
      endcase
    end
    return k;
  endfunction

  function automatic sde_req_t random_req(int insert_pct);
    sde_req_t    r;
    int unsigned roll = $urandom_range(0, 99);
    r.key   = pick_key();
    r.op    = 3'($urandom_range(0, 7));
    r.index = 8'($urandom());
    if (roll < insert_pct) begin
      r.func = FUNC_INSERT;
    end else if (roll < insert_pct + (100 - insert_pct) / 2) begin
      r.func = FUNC_SEARCH;
    end else if (roll < 97) begin
      r.func = FUNC_LOOKUP;
      if ($urandom_range(0, 2) != 0)
        r.index = 8'($urandom_range(0, dict_count < DEPTH ? dict_count : DEPTH - 1));
    end else begin
      r.func = FUNC_UNUSED;
    end
    return r;
  endfunction

  function automatic dir_row_t row(logic [1:0] f, logic [31:0] k, logic [2:0] o,
                                   logic [7:0] ix, bit known = 1'b0,
                                   logic [1:0] st = STAT_OK, logic [7:0] pos = '0,
                                   bit added = 1'b0, logic [31:0] val = '0);
    dir_row_t d;
    d.req.func          = f;
    d.req.key           = k;
    d.req.op            = o;
    d.req.index         = ix;
    d.known             = known;
    d.rsp               = '0;
    d.rsp.status        = st;
    d.rsp.position      = pos;
    d.rsp.was_added     = added;
    d.rsp.entry_value   = val;
    return d;
  endfunction

  task automatic send_item(sde_req_t r, bit known, sde_rsp_t typed);
    sde_rsp_t want;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {5'd0, r.index, r.op, r.key};
    in_tuser  <= r.func;
    do @(posedge clk); while (!in_tready);
    want = dict_apply(r);
    pending_q = {pending_q, known ? typed : want};
    n_sent++;
    if (r.func == FUNC_INSERT && want.was_added) n_added++;
    if (want.status == STAT_FULL) n_full++;
    if (r.func == FUNC_SEARCH) n_search++;
    if (r.func == FUNC_LOOKUP) n_lookup++;
    if (!calm && $urandom_range(0, 99) < gap_odds) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat ($urandom_range(0, 11)) @(negedge clk);
    end
  endtask

  task automatic cmp_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  task automatic check_result(logic [71:0] data, logic [1:0] user);
    sde_rsp_t want;
    if (pending_q.size() == 0) begin
      $error("result transfer with nothing expected: status %0d data 0x%0h", user, data);
      errors++;
      return;
    end
    want = pending_q.pop_front();
    cmp_field("status",            32'(want.status),            32'(user));
    cmp_field("position",          32'(want.position),          32'(data[7:0]));
    cmp_field("was_added",         32'(want.was_added),         32'(data[8]));
    cmp_field("range_first",       32'(want.range_first),       32'(data[17:9]));
    cmp_field("range_end",         32'(want.range_end),         32'(data[26:18]));
    cmp_field("has_excluded",      32'(want.has_excluded),      32'(data[27]));
    cmp_field("excluded_position", 32'(want.excluded_position), 32'(data[35:28]));
    cmp_field("entry_value",       want.entry_value,            data[67:36]);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_result(out_tdata, out_tuser);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** sorted_dictionary_encoder: FAILED **");
      $finish;
    end
  end

  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 99) < stall_odds) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 11)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    dir_row_t plan[$];
    sde_req_t r;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    rst_n     = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty table
    plan = {plan, row(FUNC_SEARCH, 32'h0000_0000, OP_EQ,   8'h00, 1, STAT_EMPTY)};
    plan = {plan, row(FUNC_SEARCH, 32'h8000_0000, OP_LIKE, 8'h00, 1, STAT_EMPTY)};
    plan = {plan, row(FUNC_LOOKUP, 32'h0000_0000, OP_EQ,   8'h00, 1, STAT_RANGE)};
    plan = {plan, row(FUNC_LOOKUP, 32'h0000_0000, OP_EQ,   8'hff, 1, STAT_RANGE)};
    plan = {plan, row(FUNC_UNUSED, 32'hffff_ffff, OP_UNUSED, 8'hff, 1, STAT_EMPTY)};
    // extremes, duplicate insert
    plan = {plan, row(FUNC_INSERT, 32'h8000_0000, OP_EQ, 8'h00, 1, STAT_OK, 8'd0, 1)};
    plan = {plan, row(FUNC_INSERT, 32'h7fff_ffff, OP_EQ, 8'h00, 1, STAT_OK, 8'd1, 1)};
    plan = {plan, row(FUNC_INSERT, 32'h0000_0000, OP_EQ, 8'h00, 1, STAT_OK, 8'd1, 1)};
    plan = {plan, row(FUNC_INSERT, 32'h0000_0000, OP_EQ, 8'h00, 1, STAT_OK, 8'd1, 0)};
    plan = {plan, row(FUNC_INSERT, 32'hffff_ffff, OP_EQ, 8'h00, 1, STAT_OK, 8'd1, 1)};
    plan = {plan, row(FUNC_LOOKUP, 32'h0000_0000, OP_EQ, 8'd0, 1, STAT_OK, 8'd0, 0,
                      32'h8000_0000)};
    plan = {plan, row(FUNC_LOOKUP, 32'h0000_0000, OP_EQ, 8'd3, 1, STAT_OK, 8'd0, 0,
                      32'h7fff_ffff)};
    plan = {plan, row(FUNC_LOOKUP, 32'h0000_0000, OP_EQ, 8'd4, 1, STAT_RANGE)};
    // every operator, with hit and miss for equal and not equal
    plan = {plan, row(FUNC_SEARCH, 32'h0000_0000, OP_EQ,     8'h00)};
    plan = {plan, row(FUNC_SEARCH, 32'h0000_0005, OP_EQ,     8'h00)};
    plan = {plan, row(FUNC_SEARCH, 32'h0000_0000, OP_NE,     8'h00)};
    plan = {plan, row(FUNC_SEARCH, 32'h0000_0005, OP_NE,     8'h00)};
    plan = {plan, row(FUNC_SEARCH, 32'h0000_0000, OP_LT,     8'h00)};
    plan = {plan, row(FUNC_SEARCH, 32'h0000_0000, OP_LE,     8'h00)};
    plan = {plan, row(FUNC_SEARCH, 32'h0000_0000, OP_GT,     8'h00)};
    plan = {plan, row(FUNC_SEARCH, 32'h8000_0000, OP_GE,     8'h00)};
    plan = {plan, row(FUNC_SEARCH, 32'h7fff_ffff, OP_GT,     8'h00)};
    plan = {plan, row(FUNC_SEARCH, 32'h8000_0000, OP_LT,     8'h00)};
    plan = {plan, row(FUNC_SEARCH, 32'h0000_0000, OP_LIKE,   8'h00)};
    plan = {plan, row(FUNC_SEARCH, 32'h0000_0000, OP_UNUSED, 8'h00)};
    foreach (plan[i]) send_item(plan[i].req, plan[i].known, plan[i].rsp);

    // table grows under a mixed load
    for (int i = 0; i < GROW_ITEMS; i++) begin
      if (i % 50 == 0) begin
        gap_odds   = $urandom_range(0, 2) * 20;
        stall_odds = $urandom_range(0, 2) * 10;
      end
      send_item(random_req(40), 1'b0, '0);
    end

    // fill up to capacity, long shifts
    while (dict_count < DEPTH) begin
      r = random_req(85);
      if (r.func == FUNC_INSERT) r.key = $urandom();
      send_item(r, 1'b0, '0);
    end

    // full table: rejected and found inserts, whole index range
    for (int i = 0; i < FULL_ITEMS; i++) begin
      if (i % 50 == 0) begin
        gap_odds   = $urandom_range(0, 2) * 20;
        stall_odds = $urandom_range(0, 2) * 10;
      end
      calm = i >= FULL_ITEMS - CALM_TAIL;
      send_item(random_req(35), 1'b0, '0);
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d transfers: %0d keys stored, %0d inserts refused on a full table,",
             n_sent, n_added, n_full);
    $display("%0d searches and %0d lookups, %0d mismatches", n_search, n_lookup, errors);
    if (errors == 0) begin
      $display("** sorted_dictionary_encoder: PASSED **");
    end else begin
      $display("** sorted_dictionary_encoder: FAILED **");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/sde_pkg.sv
rtl/sde_engine.sv
rtl/sorted_dictionary_encoder.sv
dv/sorted_dictionary_encoder_tb.sv
